// ===== sv/tpsc_pkg.sv =====
// Shared widths, Pade coefficients and pipeline control type for the tanh soft clipper.
// Used by every module of the clipper; depends on nothing else.
package tpsc_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;

   // Fixed-point magnitudes: x has 28 fraction bits, the polynomials 16 fraction bits.
   localparam int XM_WIDTH = 32;
   localparam int SQ_WIDTH = 2 * XM_WIDTH;
   localparam int U_WIDTH  = 23;
   localparam int A_WIDTH  = 25;
   localparam int B_WIDTH  = 32;
   localparam int C_WIDTH  = 38;
   localparam int E_WIDTH  = 29;
   localparam int F_WIDTH  = 35;
   localparam int G_WIDTH  = 41;
   localparam int N_WIDTH  = 42;
   localparam int FRAC     = 16;
   localparam int U_SHIFT  = 40;
   localparam int XL_WIDTH = 14;
   localparam int XH_WIDTH = XM_WIDTH - XL_WIDTH;
   localparam int PH_WIDTH = XH_WIDTH + C_WIDTH;
   localparam int PL_WIDTH = XL_WIDTH + C_WIDTH;

   localparam logic [A_WIDTH-1:0] K_378       = A_WIDTH'(64'd378 << FRAC);
   localparam logic [B_WIDTH-1:0] K_17325     = B_WIDTH'(64'd17325 << FRAC);
   localparam logic [C_WIDTH-1:0] K_135135_N  = C_WIDTH'(64'd135135 << FRAC);
   localparam logic [E_WIDTH-1:0] K_3150      = E_WIDTH'(64'd3150 << FRAC);
   localparam logic [F_WIDTH-1:0] K_62370     = F_WIDTH'(64'd62370 << FRAC);
   localparam logic [G_WIDTH-1:0] K_135135_D  = G_WIDTH'(64'd135135 << FRAC);

   typedef struct packed {
      logic valid;
      logic neg;
      logic sat;
   } pipe_ctrl_type;

endpackage

// ===== sv/tpsc_poly.sv =====
// Front pipeline of the clipper: magnitude, x^2 and both Horner chains, then x*numerator.
// Six register stages; depends on tpsc_pkg.
module tpsc_poly
   import tpsc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   output pipe_ctrl_type           out_ctrl,
   output logic [N_WIDTH-1:0]      out_n,
   output logic [G_WIDTH-1:0]      out_g
);

   localparam int STAGES   = 6;
   localparam int PA_WIDTH = U_WIDTH + A_WIDTH;
   localparam int PE_WIDTH = U_WIDTH + E_WIDTH;
   localparam int PB_WIDTH = U_WIDTH + B_WIDTH;
   localparam int PF_WIDTH = U_WIDTH + F_WIDTH;
   localparam logic [SQ_WIDTH-1:0] SQ_HALF = SQ_WIDTH'(1) << (U_SHIFT - 1);

   pipe_ctrl_type ctrl_ff [STAGES];
   pipe_ctrl_type ctrl_in [STAGES];

   logic [SAMPLE_WIDTH-1:0] mag;
   logic [SQ_WIDTH-1:0]     sq;
   logic [A_WIDTH-1:0]      a;
   logic [E_WIDTH-1:0]      e;
   logic [PA_WIDTH-1:0]     pa;
   logic [PE_WIDTH-1:0]     pe;
   logic [PB_WIDTH-1:0]     pb;
   logic [PF_WIDTH-1:0]     pf;
   logic [PL_WIDTH-1:0]     pl;
   logic [PH_WIDTH-1:0]     sum;

   logic [XM_WIDTH-1:0] xm1_ff, xm1_in, xm2_ff, xm3_ff, xm4_ff;
   logic [U_WIDTH-1:0]  u2_ff, u2_in, u3_ff;
   logic [B_WIDTH-1:0]  b3_ff, b3_in;
   logic [F_WIDTH-1:0]  f3_ff, f3_in;
   logic [C_WIDTH-1:0]  c4_ff, c4_in;
   logic [G_WIDTH-1:0]  g4_ff, g4_in, g5_ff, g6_ff;
   logic [PH_WIDTH-1:0] ph5_ff, ph5_in;
   logic [C_WIDTH-1:0]  pl5_ff, pl5_in;
   logic [N_WIDTH-1:0]  n6_ff, n6_in;

   always_comb begin
      ctrl_in[0].valid = in_valid;
      ctrl_in[0].neg   = sample[SAMPLE_WIDTH-1];
      ctrl_in[0].sat   = 1'b0;
      for (int i = 1; i < STAGES; i++) begin
         ctrl_in[i] = ctrl_ff[i-1];
      end

      // The curve is odd, so all arithmetic runs on the magnitude.
      mag    = sample[SAMPLE_WIDTH-1] ? (~sample + SAMPLE_WIDTH'(1)) : sample;
      xm1_in = XM_WIDTH'(mag) << (XM_WIDTH - SAMPLE_WIDTH);

      sq    = SQ_WIDTH'(xm1_ff) * SQ_WIDTH'(xm1_ff);
      u2_in = U_WIDTH'((sq + SQ_HALF) >> U_SHIFT);

      a     = A_WIDTH'(u2_ff) + K_378;
      pa    = PA_WIDTH'(u2_ff) * PA_WIDTH'(a);
      b3_in = B_WIDTH'((pa + (PA_WIDTH'(1) << (FRAC - 1))) >> FRAC) + K_17325;
      e     = (E_WIDTH'(u2_ff) << 5) - (E_WIDTH'(u2_ff) << 2) + K_3150;
      pe    = PE_WIDTH'(u2_ff) * PE_WIDTH'(e);
      f3_in = F_WIDTH'((pe + (PE_WIDTH'(1) << (FRAC - 1))) >> FRAC) + K_62370;

      pb    = PB_WIDTH'(u3_ff) * PB_WIDTH'(b3_ff);
      c4_in = C_WIDTH'((pb + (PB_WIDTH'(1) << (FRAC - 1))) >> FRAC) + K_135135_N;
      pf    = PF_WIDTH'(u3_ff) * PF_WIDTH'(f3_ff);
      g4_in = G_WIDTH'((pf + (PF_WIDTH'(1) << (FRAC - 1))) >> FRAC) + K_135135_D;

      // x*c is split so that each product stays narrow; the low part is floored first.
      ph5_in = PH_WIDTH'(xm4_ff[XM_WIDTH-1:XL_WIDTH]) * PH_WIDTH'(c4_ff);
      pl     = PL_WIDTH'(xm4_ff[XL_WIDTH-1:0]) * PL_WIDTH'(c4_ff);
      pl5_in = C_WIDTH'(pl >> XL_WIDTH);

      sum   = ph5_ff + PH_WIDTH'(pl5_ff);
      n6_in = N_WIDTH'(sum >> XL_WIDTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else if (en) begin
         for (int i = 0; i < STAGES; i++) begin
            ctrl_ff[i] <= ctrl_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xm1_ff <= xm1_in;
         xm2_ff <= xm1_ff;
         u2_ff  <= u2_in;
         xm3_ff <= xm2_ff;
         u3_ff  <= u2_ff;
         b3_ff  <= b3_in;
         f3_ff  <= f3_in;
         xm4_ff <= xm3_ff;
         c4_ff  <= c4_in;
         g4_ff  <= g4_in;
         g5_ff  <= g4_ff;
         ph5_ff <= ph5_in;
         pl5_ff <= pl5_in;
         g6_ff  <= g5_ff;
         n6_ff  <= n6_in;
      end
   end

   assign out_ctrl = ctrl_ff[STAGES-1];
   assign out_n    = n6_ff;
   assign out_g    = g6_ff;

endmodule

// ===== sv/tpsc_div_step.sv =====
// One stage of the restoring divider: develops one quotient bit and registers it.
// Depends on tpsc_pkg.
module tpsc_div_step
   import tpsc_pkg::*;
#(
   parameter int Q_WIDTH = SAMPLE_WIDTH_DEF - 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  pipe_ctrl_type       in_ctrl,
   input  logic [G_WIDTH-1:0]  in_r,
   input  logic [Q_WIDTH-1:0]  in_q,
   input  logic [G_WIDTH-1:0]  in_g,
   output pipe_ctrl_type       out_ctrl,
   output logic [G_WIDTH-1:0]  out_r,
   output logic [Q_WIDTH-1:0]  out_q,
   output logic [G_WIDTH-1:0]  out_g
);

   pipe_ctrl_type      ctrl_ff;
   logic [G_WIDTH:0]   shifted;
   logic [G_WIDTH:0]   diff;
   logic               take;
   logic [G_WIDTH-1:0] r_ff, r_in;
   logic [Q_WIDTH-1:0] q_ff, q_in;
   logic [G_WIDTH-1:0] g_ff;

   always_comb begin
      shifted = {in_r, 1'b0};
      diff    = shifted - {1'b0, in_g};
      take    = (shifted >= {1'b0, in_g});
      // The remainder stays below the divisor, so it fits back in G_WIDTH bits.
      r_in    = take ? diff[G_WIDTH-1:0] : shifted[G_WIDTH-1:0];
      q_in    = {in_q[Q_WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
         q_ff <= q_in;
         g_ff <= in_g;
      end
   end

   assign out_ctrl = ctrl_ff;
   assign out_r    = r_ff;
   assign out_q    = q_ff;
   assign out_g    = g_ff;

endmodule

// ===== sv/tpsc_divider.sv =====
// Pipelined restoring divider n/g, one quotient bit per stage, plus the saturation flag.
// Depends on tpsc_pkg and tpsc_div_step.
module tpsc_divider
   import tpsc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  pipe_ctrl_type           in_ctrl,
   input  logic [N_WIDTH-1:0]      in_n,
   input  logic [G_WIDTH-1:0]      in_g,
   output pipe_ctrl_type           out_ctrl,
   output logic [SAMPLE_WIDTH-2:0] out_q
);

   // One extra quotient bit below the output precision feeds the rounding.
   localparam int STEPS   = SAMPLE_WIDTH - 1;
   localparam int Q_WIDTH = SAMPLE_WIDTH - 1;

   pipe_ctrl_type      ctrl_w [STEPS+1];
   logic [G_WIDTH-1:0] r_w    [STEPS+1];
   logic [Q_WIDTH-1:0] q_w    [STEPS+1];
   logic [G_WIDTH-1:0] g_w    [STEPS+1];

   // A ratio of one or more saturates; the quotient bits are then ignored.
   always_comb begin
      ctrl_w[0].valid = in_ctrl.valid;
      ctrl_w[0].neg   = in_ctrl.neg;
      ctrl_w[0].sat   = (in_n >= N_WIDTH'(in_g));
      r_w[0]          = in_n[G_WIDTH-1:0];
      q_w[0]          = '0;
      g_w[0]          = in_g;
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      tpsc_div_step #(
         .Q_WIDTH (Q_WIDTH)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_ctrl  (ctrl_w[i]),
         .in_r     (r_w[i]),
         .in_q     (q_w[i]),
         .in_g     (g_w[i]),
         .out_ctrl (ctrl_w[i+1]),
         .out_r    (r_w[i+1]),
         .out_q    (q_w[i+1]),
         .out_g    (g_w[i+1])
      );
   end

   assign out_ctrl = ctrl_w[STEPS];
   assign out_q    = q_w[STEPS];

endmodule

// ===== sv/tanh_pade_soft_clipper.sv =====
// Soft clipper using the [7/6] Pade approximation of tanh, clamped to -1..+1.
// The pipeline has six polynomial stages, SAMPLE_WIDTH-1 divider stages each producing one
// quotient bit, and the output register.
// Throughput is one request per cycle; the whole pipeline holds while the output is stalled.
// Synchronous reset clears only the valid bits and the control flags; the data registers are not reset.
// Depends on tpsc_pkg, tpsc_poly and tpsc_divider.
module tanh_pade_soft_clipper
   import tpsc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // sample_in
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] rsp_tdata   // sample_out
);

   localparam int DATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int Q_WIDTH    = SAMPLE_WIDTH - 1;
   localparam logic [Q_WIDTH-1:0] ONE = Q_WIDTH'(1) << (SAMPLE_WIDTH - 2);

   logic                    en;
   pipe_ctrl_type           poly_ctrl;
   logic [N_WIDTH-1:0]      poly_n;
   logic [G_WIDTH-1:0]      poly_g;
   pipe_ctrl_type           div_ctrl;
   logic [Q_WIDTH-1:0]      div_q;
   logic [SAMPLE_WIDTH-1:0] q_plus;
   logic [Q_WIDTH-1:0]      q_round;
   logic [Q_WIDTH-1:0]      mag;
   logic                    rsp_tvalid_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;

   // Everything advances together whenever the output register is free or being emptied.
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   tpsc_poly #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_poly (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .sample   (req_tdata[SAMPLE_WIDTH-1:0]),
      .out_ctrl (poly_ctrl),
      .out_n    (poly_n),
      .out_g    (poly_g)
   );

   tpsc_divider #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_ctrl  (poly_ctrl),
      .in_n     (poly_n),
      .in_g     (poly_g),
      .out_ctrl (div_ctrl),
      .out_q    (div_q)
   );

   always_comb begin
      q_plus  = {1'b0, div_q} + SAMPLE_WIDTH'(1);
      q_round = q_plus[SAMPLE_WIDTH-1:1];
      mag     = (div_ctrl.sat || (q_round > ONE)) ? ONE : q_round;
      rsp_sample_in = div_ctrl.neg ? (SAMPLE_WIDTH'(0) - {1'b0, mag}) : {1'b0, mag};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= div_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = DATA_WIDTH'(rsp_sample_ff);

endmodule
